>>> rtl/core/rhwm_pkg.sv
// Shared types and constants for the rolling hash window matcher.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package rhwm_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int MAX_ENTRIES = 1024;

  localparam int LEN_W  = 9;   // window length register and bytes seen
  localparam int HIST_AW = 8;  // byte history address
  localparam int TBL_AW = 10;  // table address
  localparam int CNT_W  = 11;  // table fill count

  localparam logic [31:0] SEED_ONE = 32'd998244351;
  localparam logic [31:0] SEED_TWO = 32'd100000007;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;
  localparam logic [63:0] POW_ONE_RESET = 64'd998244351;
  localparam logic [63:0] POW_TWO_RESET = 64'd100000007;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_PROBE   = 2'd2;

  localparam logic [1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [1:0] CFG_POWER_ONE  = 2'd1;
  localparam logic [1:0] CFG_POWER_TWO  = 2'd2;

  typedef enum logic [2:0] {
    OP_RESTART,
    OP_LOAD,
    OP_PROBE_NEW,
    OP_PROBE,
    OP_IGNORE
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage

>>> rtl/core/rhwm_front.sv
// Front end: takes input transfers and classifies each command into an op.
// Depends on rhwm_pkg; feeds rhwm_fifo.
module rhwm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_byte_value,
  input  logic             q_full,
  output logic             in_ready,
  output logic             q_push,
  output rhwm_pkg::op_t    q_op
);

  logic probing_r;
  logic probing_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    probing_nxt = probing_r;
    q_op.data   = in_byte_value;
    q_op.kind   = rhwm_pkg::OP_IGNORE;
    case (in_command)
      rhwm_pkg::CMD_RESTART: begin
        q_op.kind   = rhwm_pkg::OP_RESTART;
        probing_nxt = 1'b0;
      end
      rhwm_pkg::CMD_LOAD: begin
        q_op.kind = probing_r ? rhwm_pkg::OP_IGNORE : rhwm_pkg::OP_LOAD;
      end
      rhwm_pkg::CMD_PROBE: begin
        q_op.kind   = probing_r ? rhwm_pkg::OP_PROBE : rhwm_pkg::OP_PROBE_NEW;
        probing_nxt = 1'b1;
      end
      default: begin
        q_op.kind = rhwm_pkg::OP_IGNORE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probing_r <= 1'b0;
    end else if (q_push) begin
      probing_r <= probing_nxt;
    end
  end

endmodule

>>> rtl/core/rhwm_fifo.sv
// Two-entry op queue between front end and back end.
// Depends on rhwm_pkg for the op type.
module rhwm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rhwm_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output rhwm_pkg::op_t head
);

  rhwm_pkg::op_t slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/rhwm_back.sv
// Back end: rolling hash update on a shared 32x32 multiplier, byte history,
// hash pair table with linear search, config registers and result register.
// Depends on rhwm_pkg; takes ops from rhwm_fifo.
module rhwm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  rhwm_pkg::op_t q_head,
  output logic          q_pop,
  input  logic          cfg_write_en,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_window_full,
  output logic          out_hit,
  output logic          out_any_hit,
  output logic [10:0]   out_entry_total,
  output logic          out_overflow
);

  rhwm_pkg::back_state_t state_r, state_nxt;

  logic [rhwm_pkg::LEN_W-1:0] len_cfg_r;
  logic [63:0] pow1_r, pow2_r;

  logic [63:0] h1_r, h1_nxt, h2_r, h2_nxt;
  logic [63:0] acc1_r, acc1_nxt, acc2_r, acc2_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        is_load_r, is_load_nxt;
  logic [rhwm_pkg::LEN_W-1:0] seen_r, seen_nxt;
  logic [rhwm_pkg::HIST_AW-1:0] wp_r, wp_nxt;
  logic [rhwm_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [rhwm_pkg::CNT_W-1:0] scan_r, scan_nxt;
  logic        cmp_v_r, cmp_v_nxt;
  logic        match_r, match_nxt;
  logic        drop_r, drop_nxt;
  logic        res_full_r, res_full_nxt;
  logic        res_hit_r, res_hit_nxt;

  logic        ov_r, ov_nxt;
  logic        o_full_r, o_hit_r, o_any_r, o_drop_r;
  logic [rhwm_pkg::CNT_W-1:0] o_total_r;
  logic        emit;

  // byte history and table memories
  logic [7:0]   hist_mem [rhwm_pkg::MAX_WINDOW];
  logic [7:0]   hist_q_r;
  logic         hist_we;
  logic [127:0] tbl_mem [rhwm_pkg::MAX_ENTRIES];
  logic [127:0] tbl_q_r;
  logic         tbl_we;

  logic [rhwm_pkg::LEN_W-1:0] len;
  logic [rhwm_pkg::HIST_AW-1:0] hist_raddr;
  logic [7:0]  lv;
  logic [31:0] mul_a, mul_b;
  logic [2:0]  k;
  logic [63:0] term;
  logic [rhwm_pkg::LEN_W-1:0] seen_inc;
  logic        full_new;

  always_comb begin
    if (len_cfg_r == '0) begin
      len = rhwm_pkg::LEN_W'(1);
    end else if (len_cfg_r > rhwm_pkg::LEN_W'(rhwm_pkg::MAX_WINDOW)) begin
      len = rhwm_pkg::LEN_W'(rhwm_pkg::MAX_WINDOW);
    end else begin
      len = len_cfg_r;
    end
  end

  // byte that leaves the window sits len entries behind the write pointer
  assign hist_raddr = wp_r - len[rhwm_pkg::HIST_AW-1:0];
  assign lv = (seen_r >= len) ? hist_q_r : 8'd0;

  always_comb begin
    case (cnt_r[2:0])
      3'd0: begin mul_a = h1_r[31:0];    mul_b = rhwm_pkg::SEED_ONE; end
      3'd1: begin mul_a = h1_r[63:32];   mul_b = rhwm_pkg::SEED_ONE; end
      3'd2: begin mul_a = pow1_r[31:0];  mul_b = {24'd0, lv}; end
      3'd3: begin mul_a = pow1_r[63:32]; mul_b = {24'd0, lv}; end
      3'd4: begin mul_a = h2_r[31:0];    mul_b = rhwm_pkg::SEED_TWO; end
      3'd5: begin mul_a = h2_r[63:32];   mul_b = rhwm_pkg::SEED_TWO; end
      3'd6: begin mul_a = pow2_r[31:0];  mul_b = {24'd0, lv}; end
      default: begin mul_a = pow2_r[63:32]; mul_b = {24'd0, lv}; end
    endcase
  end

  assign prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

  assign k = cnt_r[2:0] - 3'd1;
  always_comb begin
    case (k[1:0])
      2'd0: term = prod_r;
      2'd1: term = {prod_r[31:0], 32'd0};
      2'd2: term = -prod_r;
      default: term = -{prod_r[31:0], 32'd0};
    endcase
  end

  assign seen_inc = (seen_r < rhwm_pkg::LEN_W'(rhwm_pkg::MAX_WINDOW)) ?
                    seen_r + rhwm_pkg::LEN_W'(1) : seen_r;
  assign full_new = (seen_inc >= len);

  assign emit = (state_r == rhwm_pkg::ST_EMIT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    h1_nxt       = h1_r;
    h2_nxt       = h2_r;
    acc1_nxt     = acc1_r;
    acc2_nxt     = acc2_r;
    cnt_nxt      = cnt_r;
    byte_nxt     = byte_r;
    is_load_nxt  = is_load_r;
    seen_nxt     = seen_r;
    wp_nxt       = wp_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    cmp_v_nxt    = cmp_v_r;
    match_nxt    = match_r;
    drop_nxt     = drop_r;
    res_full_nxt = res_full_r;
    res_hit_nxt  = res_hit_r;
    ov_nxt       = ov_r && !out_ready;
    q_pop        = 1'b0;
    hist_we      = 1'b0;
    tbl_we       = 1'b0;

    case (state_r)
      rhwm_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          byte_nxt    = q_head.data;
          res_hit_nxt = 1'b0;
          cnt_nxt     = 4'd0;
          is_load_nxt = (q_head.kind == rhwm_pkg::OP_LOAD);
          case (q_head.kind)
            rhwm_pkg::OP_RESTART: begin
              h1_nxt       = '0;
              h2_nxt       = '0;
              seen_nxt     = '0;
              count_nxt    = '0;
              match_nxt    = 1'b0;
              drop_nxt     = 1'b0;
              res_full_nxt = 1'b0;
              state_nxt    = rhwm_pkg::ST_EMIT;
            end
            rhwm_pkg::OP_LOAD, rhwm_pkg::OP_PROBE: begin
              state_nxt = rhwm_pkg::ST_MUL;
            end
            rhwm_pkg::OP_PROBE_NEW: begin
              h1_nxt    = '0;
              h2_nxt    = '0;
              seen_nxt  = '0;
              state_nxt = rhwm_pkg::ST_MUL;
            end
            default: begin
              res_full_nxt = (seen_r >= len);
              state_nxt    = rhwm_pkg::ST_EMIT;
            end
          endcase
        end
      end
      rhwm_pkg::ST_MUL: begin
        // product k is formed at count k and summed in at count k+1
        if (cnt_r == 4'd0) begin
          acc1_nxt = {56'd0, byte_r};
          acc2_nxt = {56'd0, byte_r};
        end else if (k[2] == 1'b0 && cnt_r != 4'd8) begin
          acc1_nxt = acc1_r + term;
        end else begin
          acc2_nxt = acc2_r + term;
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) begin
          state_nxt = rhwm_pkg::ST_FIN;
        end
      end
      rhwm_pkg::ST_FIN: begin
        h1_nxt       = acc1_r;
        h2_nxt       = acc2_r;
        hist_we      = 1'b1;
        wp_nxt       = wp_r + rhwm_pkg::HIST_AW'(1);
        seen_nxt     = seen_inc;
        res_full_nxt = full_new;
        scan_nxt     = '0;
        cmp_v_nxt    = 1'b0;
        state_nxt    = rhwm_pkg::ST_EMIT;
        if (full_new) begin
          if (is_load_r) begin
            if (count_r < rhwm_pkg::CNT_W'(rhwm_pkg::MAX_ENTRIES)) begin
              tbl_we    = 1'b1;
              count_nxt = count_r + rhwm_pkg::CNT_W'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else if (count_r != '0) begin
            state_nxt = rhwm_pkg::ST_SCAN;
          end
        end
      end
      rhwm_pkg::ST_SCAN: begin
        cmp_v_nxt = (scan_r < count_r);
        scan_nxt  = scan_r + rhwm_pkg::CNT_W'(1);
        if (scan_r != '0) begin
          if (cmp_v_r && tbl_q_r == {h1_r, h2_r}) begin
            res_hit_nxt = 1'b1;
            match_nxt   = 1'b1;
            state_nxt   = rhwm_pkg::ST_EMIT;
          end else if (!cmp_v_r) begin
            state_nxt = rhwm_pkg::ST_EMIT;
          end
        end
      end
      rhwm_pkg::ST_EMIT: begin
        if (emit) begin
          ov_nxt    = 1'b1;
          state_nxt = rhwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rhwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hist_q_r <= hist_mem[hist_raddr];
    if (hist_we) begin
      hist_mem[wp_r] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    tbl_q_r <= tbl_mem[scan_r[rhwm_pkg::TBL_AW-1:0]];
    if (tbl_we) begin
      tbl_mem[count_r[rhwm_pkg::TBL_AW-1:0]] <= {acc1_r, acc2_r};
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    acc1_r     <= acc1_nxt;
    acc2_r     <= acc2_nxt;
    byte_r     <= byte_nxt;
    is_load_r  <= is_load_nxt;
    scan_r     <= scan_nxt;
    res_full_r <= res_full_nxt;
    res_hit_r  <= res_hit_nxt;
    if (emit) begin
      o_full_r  <= res_full_r;
      o_hit_r   <= res_hit_r;
      o_any_r   <= match_r;
      o_total_r <= count_r;
      o_drop_r  <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rhwm_pkg::ST_IDLE;
      len_cfg_r <= rhwm_pkg::LEN_RESET;
      pow1_r    <= rhwm_pkg::POW_ONE_RESET;
      pow2_r    <= rhwm_pkg::POW_TWO_RESET;
      h1_r      <= '0;
      h2_r      <= '0;
      cnt_r     <= '0;
      seen_r    <= '0;
      wp_r      <= '0;
      count_r   <= '0;
      cmp_v_r   <= 1'b0;
      match_r   <= 1'b0;
      drop_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
      match_r <= match_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          rhwm_pkg::CFG_WINDOW_LEN: len_cfg_r <= cfg_data[rhwm_pkg::LEN_W-1:0];
          rhwm_pkg::CFG_POWER_ONE:  pow1_r <= cfg_data;
          rhwm_pkg::CFG_POWER_TWO:  pow2_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_window_full = o_full_r;
  assign out_hit         = o_hit_r;
  assign out_any_hit     = o_any_r;
  assign out_entry_total = o_total_r;
  assign out_overflow    = o_drop_r;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rhwm_pkg::CNT_W'(rhwm_pkg::MAX_ENTRIES))
    else $error("table count above capacity");
  a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_hit_r |-> o_full_r && o_any_r)
    else $error("hit without full window or sticky flag");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(drop_r) |-> count_r == rhwm_pkg::CNT_W'(rhwm_pkg::MAX_ENTRIES))
    else $error("load dropped while table not full");
`endif

endmodule

>>> rtl/core/rolling_hash_window_matcher.sv
// Restart and ignored commands go from idle to the emit state; load and probe bytes
// pass the multiply state (eight partial products on one shared 32x32 multiplier)
// and a finish state, and a probe with a full window and a non-empty table adds a
// linear search. Items go one at a time; a two-entry op queue takes new ones meanwhile.
// Reset (rst_n low, synchronous) clears control state, hashes, counts and flags,
// and loads the register defaults; table and byte history need no clearing.
module rolling_hash_window_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_window_full,
  output logic        out_hit,
  output logic        out_any_hit,
  output logic [10:0] out_entry_total,
  output logic        out_overflow,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic          q_full, q_empty, q_push, q_pop;
  rhwm_pkg::op_t q_op, q_head;

  rhwm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_command    (in_command),
    .in_byte_value (in_byte_value),
    .q_full        (q_full),
    .in_ready      (in_ready),
    .q_push        (q_push),
    .q_op          (q_op)
  );

  rhwm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  rhwm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_window_full (out_window_full),
    .out_hit         (out_hit),
    .out_any_hit     (out_any_hit),
    .out_entry_total (out_entry_total),
    .out_overflow    (out_overflow)
  );

endmodule
